>>> design/mm4_pkg.sv
package mm4_pkg;

	localparam int DIM    = 4;
	localparam int CELLS  = DIM * DIM;
	localparam int IDX_W  = 4;
	localparam int DATA_W = 32;
	localparam int FRAC_W = 16;
	localparam int CNT_W  = (DIM > 1) ? $clog2(DIM) : 1;
	localparam int PROD_W = 2 * DATA_W;
	localparam int SHP_W  = PROD_W - FRAC_W;
	localparam int ACC_W  = SHP_W + CNT_W;

	typedef struct packed {
		logic [IDX_W-1:0]         element_index;
		logic signed [DATA_W-1:0] first_element;
		logic signed [DATA_W-1:0] second_element;
		logic                     load_done;
	} load_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]         result_index;
		logic signed [DATA_W-1:0] result_element;
		logic                     saturated;
		logic                     last_result;
	} result_item_t;

	typedef struct packed {
		logic             issue;
		logic             first;
		logic             last;
		logic [IDX_W-1:0] a_addr;
		logic [IDX_W-1:0] b_addr;
		logic [IDX_W-1:0] pos;
	} ctl_cmd_t;

	typedef struct packed {
		logic advance;
		logic busy;
	} ctl_status_t;

endpackage

>>> design/matrix4x4_multiply_engine_unit.sv
// A load beat with load_done starts a run. Each product passes the registered store
//   reads, the product register and the accumulator; sums wait at the output.
// Each result takes one shared multiply-accumulate step per k; output stalls hold
//   the run. load_ready returns once the last multiply issue has drained.
// Reset (arst_n, async, active low) clears the sequencer and valid flags; the
//   operand stores are undefined until written.
module matrix4x4_multiply_engine_unit import mm4_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load_valid,
	output logic         load_ready,
	input  load_item_t   load_item,
	output logic         result_valid,
	input  logic         result_ready,
	output result_item_t result_item
);

	ctl_cmd_t    cmd;
	ctl_status_t stat;
	logic        idle;
	logic        load_accept;

	// Take load beats only while no run is in flight, so store writes never
	// race the multiply reads. A result may still wait at the output.
	assign load_ready  = idle;
	assign load_accept = load_valid && load_ready;

	// Sequencer: walks column, row and k, issuing one multiply per unstalled cycle.
	mm4_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (load_accept && load_item.load_done),
		.stat   (stat),
		.cmd    (cmd),
		.idle   (idle)
	);

	// Datapath: operand stores, registered reads, multiplier, accumulator,
	// saturation and the output register that parts the result side.
	mm4_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (load_accept),
		.wr_item   (load_item),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (result_valid),
		.out_ready (result_ready),
		.out_item  (result_item)
	);

endmodule

>>> design/mm4_ctrl.sv
module mm4_ctrl import mm4_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  ctl_status_t stat,
	output ctl_cmd_t    cmd,
	output logic        idle
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic             state_q;
	logic [CNT_W-1:0] k_q;
	logic [CNT_W-1:0] row_q;
	logic [CNT_W-1:0] col_q;
	logic             k_end;
	logic             row_end;
	logic             col_end;

	assign k_end   = (k_q == CNT_W'(DIM - 1));
	assign row_end = (row_q == CNT_W'(DIM - 1));
	assign col_end = (col_q == CNT_W'(DIM - 1));

	// Step k fastest, then row, then column: results leave in storage order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			row_q   <= '0;
			col_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RUN;
						k_q     <= '0;
						row_q   <= '0;
						col_q   <= '0;
					end
				end
				ST_RUN: begin
					if (stat.advance) begin
						if (k_end) begin
							k_q <= '0;
							if (row_end) begin
								row_q <= '0;
								if (col_end) begin
									col_q   <= '0;
									state_q <= ST_IDLE;
								end else begin
									col_q <= col_q + 1'b1;
								end
							end else begin
								row_q <= row_q + 1'b1;
							end
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.issue  = (state_q == ST_RUN);
		cmd.first  = (k_q == '0);
		cmd.last   = k_end;
		cmd.a_addr = IDX_W'(k_q) * IDX_W'(DIM) + IDX_W'(row_q);
		cmd.b_addr = IDX_W'(col_q) * IDX_W'(DIM) + IDX_W'(k_q);
		cmd.pos    = IDX_W'(col_q) * IDX_W'(DIM) + IDX_W'(row_q);
	end

	assign idle = (state_q == ST_IDLE) && !stat.busy;

	a_start_run: assert property (@(posedge clk) disable iff (!arst_n)
		start && state_q == ST_IDLE |=> state_q == ST_RUN && k_q == '0 && row_q == '0
			&& col_q == '0)
		else $error("run did not begin at the first element");

	a_end_run: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN && stat.advance && k_end && row_end && col_end
			|=> state_q == ST_IDLE)
		else $error("run did not end after the last issue");

endmodule

>>> design/mm4_datapath.sv
module mm4_datapath import mm4_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  load_item_t   wr_item,
	input  ctl_cmd_t     cmd,
	output ctl_status_t  stat,
	output logic         out_valid,
	input  logic         out_ready,
	output result_item_t out_item
);

	logic [DATA_W-1:0] first_mem  [CELLS];
	logic [DATA_W-1:0] second_mem [CELLS];

	logic                     advance;
	logic                     valid_s1;
	logic                     first_s1;
	logic                     last_s1;
	logic [IDX_W-1:0]         pos_s1;
	logic signed [DATA_W-1:0] a_rd_s1;
	logic signed [DATA_W-1:0] b_rd_s1;
	logic                     valid_s2;
	logic                     first_s2;
	logic                     last_s2;
	logic [IDX_W-1:0]         pos_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  sum;
	logic                     clip;
	logic                     out_valid_q;
	result_item_t             out_item_q;

	// Hold every stage while a result waits in the output register.
	assign advance = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (wr_en && ({1'b0, wr_item.element_index} < (IDX_W + 1)'(CELLS))) begin
			first_mem[wr_item.element_index]  <= wr_item.first_element;
			second_mem[wr_item.element_index] <= wr_item.second_element;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			a_rd_s1  <= first_mem[cmd.a_addr];
			b_rd_s1  <= second_mem[cmd.b_addr];
			first_s1 <= cmd.first;
			last_s1  <= cmd.last;
			pos_s1   <= cmd.pos;
			prod_s2  <= a_rd_s1 * b_rd_s1;
			first_s2 <= first_s1;
			last_s2  <= last_s1;
			pos_s2   <= pos_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
		end
	end

	// Drop the low 16 product bits (floor shift), then add to the running sum.
	always_comb begin
		sum  = (first_s2 ? '0 : acc_q) + ACC_W'($signed(prod_s2[PROD_W-1:FRAC_W]));
		clip = (sum[ACC_W-1:DATA_W-1] != '0) && (sum[ACC_W-1:DATA_W-1] != '1);
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s2) begin
			acc_q <= sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s2 && last_s2) begin
			out_item_q.result_index <= pos_s2;
			out_item_q.saturated    <= clip;
			out_item_q.last_result  <= (pos_s2 == IDX_W'(CELLS - 1));
			if (clip) begin
				out_item_q.result_element <= sum[ACC_W-1] ?
					{1'b1, {(DATA_W - 1){1'b0}}} : {1'b0, {(DATA_W - 1){1'b1}}};
			end else begin
				out_item_q.result_element <= sum[DATA_W-1:0];
			end
		end
	end

	assign stat.advance = advance;
	assign stat.busy    = valid_s1 || valid_s2;
	assign out_valid    = out_valid_q;
	assign out_item     = out_item_q;

	a_capture: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && last_s2 && advance |=> out_valid_q)
		else $error("finished sum not captured");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !advance |=> valid_s2 && $stable(prod_s2) && $stable(pos_s2))
		else $error("product stage moved during stall");

endmodule

>>> test/mm4_product_checker.sv
module mm4_product_checker import mm4_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load_valid,
	input  logic         load_ready,
	input  load_item_t   load_item,
	input  logic         result_valid,
	input  logic         result_ready,
	input  result_item_t result_item,
	output int           mismatches,
	output int           pending
);

	localparam int     REPORT_LIMIT = 10;
	localparam longint SUM_MAX      = (64'sd1 <<< (DATA_W - 1)) - 64'sd1;
	localparam longint SUM_MIN      = -(64'sd1 <<< (DATA_W - 1));

	logic signed [DATA_W-1:0] first_mat [CELLS];
	logic signed [DATA_W-1:0] second_mat [CELLS];
	result_item_t             product_q [$];
	int                       bad_count;

	// Queue every element of first * second, storage order, column-major.
	task automatic queue_product();
		longint       acc;
		longint       prod;
		result_item_t elem;
		int           col;
		int           row;
		int           k;
		for (col = 0; col < DIM; col++) begin
			for (row = 0; row < DIM; row++) begin
				acc = 0;
				for (k = 0; k < DIM; k++) begin
					prod = longint'(first_mat[k * DIM + row]) *
						longint'(second_mat[col * DIM + k]);
					// arithmetic shift floors toward minus infinity
					acc += prod >>> FRAC_W;
				end
				elem.result_index = IDX_W'(col * DIM + row);
				elem.saturated    = 1'b1;
				if (acc > SUM_MAX)
					elem.result_element = DATA_W'(SUM_MAX);
				else if (acc < SUM_MIN)
					elem.result_element = DATA_W'(SUM_MIN);
				else begin
					elem.result_element = DATA_W'(acc);
					elem.saturated      = 1'b0;
				end
				elem.last_result = (col * DIM + row == CELLS - 1);
				product_q.push_back(elem);
			end
		end
	endtask

	task automatic check_result(input result_item_t got);
		result_item_t want;
		if (product_q.size() == 0) begin
			bad_count++;
			if (bad_count <= REPORT_LIMIT)
				$display("%0t: result beat with nothing pending: idx %0d elem %h sat %b last %b",
					$time, got.result_index, got.result_element, got.saturated,
					got.last_result);
			return;
		end
		want = product_q.pop_front();
		if (got.result_index !== want.result_index ||
			got.result_element !== want.result_element ||
			got.saturated !== want.saturated ||
			got.last_result !== want.last_result) begin
			bad_count++;
			if (bad_count <= REPORT_LIMIT)
				$display("%0t: result mismatch: expected idx %0d elem %h sat %b last %b, got idx %0d elem %h sat %b last %b",
					$time, want.result_index, want.result_element, want.saturated,
					want.last_result, got.result_index, got.result_element,
					got.saturated, got.last_result);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			product_q.delete();
			bad_count = 0;
			mismatches <= 0;
			pending    <= 0;
		end else begin
			// results in flight belong to an earlier run, so check them first
			if (result_valid && result_ready)
				check_result(result_item);
			if (load_valid && load_ready) begin
				first_mat[load_item.element_index]  = load_item.first_element;
				second_mat[load_item.element_index] = load_item.second_element;
				if (load_item.load_done)
					queue_product();
			end
			mismatches <= bad_count;
			pending    <= product_q.size();
		end
	end

endmodule

>>> test/tb_top.sv
module tb_top;
	import mm4_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on either channel
	localparam int TOTAL_LOADS    = 230;
	localparam int CALM_FROM      = 190;   // no idling from here on
	localparam int DRAIN_CYCLES   = 24;    // latency tail after the last result

	localparam logic signed [DATA_W-1:0] Q_MIN     = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] Q_MAX     = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] Q_ZERO    = 32'sh0000_0000;
	localparam logic signed [DATA_W-1:0] Q_ONE     = 32'sh0001_0000;
	localparam logic signed [DATA_W-1:0] Q_ULP     = 32'sh0000_0001;
	localparam logic signed [DATA_W-1:0] Q_NEG_ULP = 32'shFFFF_FFFF;

	// Magnitude classes for random operand content.
	typedef enum int {SPAN_SMALL, SPAN_MEDIUM, SPAN_FULL, SPAN_EXTREME} span_e;
	// Shapes of a random load sequence.
	typedef enum int {SEQ_FULL, SEQ_PARTIAL, SEQ_NOISE} seq_e;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         load_valid;
	logic         load_ready;
	load_item_t   load_item;
	logic         result_valid;
	logic         result_ready;
	result_item_t result_item;

	int mismatches;
	int pending;
	int loads_sent;
	bit calm;       // set in the last part of the run: both sides stop idling
	bit gap_free;   // set per sequence: the sender runs back to back

	always #6 clk = ~clk;

	matrix4x4_multiply_engine_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.load_valid   (load_valid),
		.load_ready   (load_ready),
		.load_item    (load_item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_item  (result_item)
	);

	mm4_product_checker product_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.load_valid   (load_valid),
		.load_ready   (load_ready),
		.load_item    (load_item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_item  (result_item),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	// Draw one Q16.16 operand. Small values never saturate, medium ones
	// sometimes do, full-range ones nearly always do.
	function automatic logic signed [DATA_W-1:0] pick_element(input span_e span);
		logic signed [DATA_W-1:0] value;
		case (span)
			SPAN_SMALL: begin
				value = $urandom_range(0, 32'h7_FFFF) - 32'h4_0000;     // +-4.0
			end
			SPAN_MEDIUM: begin
				value = $urandom_range(0, 32'hFF_FFFF) - 32'h80_0000;   // +-128.0
			end
			SPAN_FULL: begin
				value = $urandom;
			end
			default: begin
				case ($urandom_range(0, 4))
					0:       value = Q_MIN;
					1:       value = Q_MAX;
					2:       value = Q_ZERO;
					3:       value = Q_NEG_ULP;
					default: value = Q_ONE;
				endcase
			end
		endcase
		return value;
	endfunction

	// Mostly follow the sequence's class, now and then mix in another one.
	function automatic span_e pick_span(input span_e seq_span);
		if ($urandom_range(0, 7) == 0)
			return span_e'($urandom_range(0, 3));
		return seq_span;
	endfunction

	// Present one load beat and hold it until accepted. An optional idle
	// burst goes first. Valid stays high into the next beat when there is
	// no gap, so it is never dropped and raised in the same step.
	task automatic send_load(input logic [IDX_W-1:0] idx,
		input logic signed [DATA_W-1:0] first_val,
		input logic signed [DATA_W-1:0] second_val,
		input logic done);
		load_item_t beat;
		beat.element_index  = idx;
		beat.first_element  = first_val;
		beat.second_element = second_val;
		beat.load_done      = done;
		if (!calm && !gap_free && $urandom_range(0, 3) == 0) begin
			load_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		load_valid <= 1'b1;
		load_item  <= beat;
		@(posedge clk);
		while (!load_ready)
			@(posedge clk);
		loads_sent++;
	endtask

	// Drop valid and hold off until every queued product element has come back.
	task automatic hold_until_drained();
		load_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Result side: random stall bursts, interleaved with ready stretches.
	initial begin
		result_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				result_ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	// Watchdog: end the run if no beat moves on either channel for too long.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((load_valid && load_ready) || (result_valid && result_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("** matrix4x4_multiply_engine_unit: FAILED **");
		$finish;
	end

	initial begin
		int                       order [CELLS];
		int                       i;
		int                       j;
		int                       tmp;
		int                       count;
		span_e                    seq_span;
		seq_e                     seq_kind;
		logic signed [DATA_W-1:0] col_val;

		arst_n     = 1'b0;
		load_valid = 1'b0;
		load_item  = '0;
		calm       = 1'b0;
		gap_free   = 1'b0;
		loads_sent = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part.
		// Fill both stores in storage order before any multiply, since an
		// unwritten entry must never be read. First operand is all minimum;
		// the second operand's columns give positive overflow (min * min),
		// negative overflow (min * max), zero, and a small exact sum
		// (min * -1 ulp).
		for (i = 0; i < CELLS; i++) begin
			case (i / DIM)
				0:       col_val = Q_MIN;
				1:       col_val = Q_MAX;
				2:       col_val = Q_ZERO;
				default: col_val = Q_NEG_ULP;
			endcase
			send_load(IDX_W'(i), Q_MIN, col_val, i == CELLS - 1);
		end
		// Let the whole product drain before the next beat.
		hold_until_drained();
		// Stores without a multiply: maximum values, then -1 ulp and one; no results expected.
		send_load(IDX_W'(0), Q_MAX, Q_MAX, 1'b0);
		send_load(IDX_W'(5), Q_NEG_ULP, Q_ONE, 1'b0);
		// Negative one-ulp products floor to -1 rather than truncating to 0.
		send_load(IDX_W'(10), Q_NEG_ULP, Q_ULP, 1'b1);
		// Rerun with the same pair: the stores must survive the earlier run.
		send_load(IDX_W'(10), Q_NEG_ULP, Q_ULP, 1'b1);
		send_load(IDX_W'(15), Q_ONE, Q_ONE, 1'b1);

		// Random part.
		while (loads_sent < TOTAL_LOADS) begin
			calm     = (loads_sent >= CALM_FROM);
			gap_free = ($urandom_range(0, 2) == 0);
			case ($urandom_range(0, 5))
				0, 1, 2: seq_span = SPAN_SMALL;
				3:       seq_span = SPAN_MEDIUM;
				4:       seq_span = SPAN_FULL;
				default: seq_span = SPAN_EXTREME;
			endcase
			tmp = $urandom_range(0, 9);
			seq_kind = (tmp < 6) ? SEQ_FULL : (tmp < 9) ? SEQ_PARTIAL : SEQ_NOISE;
			case (seq_kind)
				SEQ_FULL: begin
					// Full reload in shuffled order, multiply on the last beat.
					for (i = 0; i < CELLS; i++)
						order[i] = i;
					for (i = CELLS - 1; i > 0; i--) begin
						j        = $urandom_range(0, i);
						tmp      = order[i];
						order[i] = order[j];
						order[j] = tmp;
					end
					for (i = 0; i < CELLS; i++)
						send_load(IDX_W'(order[i]), pick_element(pick_span(seq_span)),
							pick_element(pick_span(seq_span)), i == CELLS - 1);
				end
				SEQ_PARTIAL: begin
					// Patch a few entries, then multiply on what is stored.
					count = $urandom_range(1, 4);
					for (i = 0; i < count; i++)
						send_load(IDX_W'($urandom_range(0, CELLS - 1)),
							pick_element(pick_span(seq_span)),
							pick_element(pick_span(seq_span)), i == count - 1);
				end
				default: begin
					// Stores only, nothing comes back.
					count = $urandom_range(1, 3);
					for (i = 0; i < count; i++)
						send_load(IDX_W'($urandom_range(0, CELLS - 1)),
							pick_element(pick_span(seq_span)),
							pick_element(pick_span(seq_span)), 1'b0);
				end
			endcase
			if (!calm && $urandom_range(0, 7) == 0)
				hold_until_drained();
		end

		// Drain: wait for every pending element, then watch the tail for strays.
		load_valid <= 1'b0;
		calm = 1'b1;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("** matrix4x4_multiply_engine_unit: PASSED **");
		else
			$display("** matrix4x4_multiply_engine_unit: FAILED **");
		$finish;
	end

endmodule

>>> sim.f
design/mm4_pkg.sv
design/mm4_ctrl.sv
design/mm4_datapath.sv
design/matrix4x4_multiply_engine_unit.sv
test/mm4_product_checker.sv
test/tb_top.sv
